@@ rtl/eps_pkg.sv @@
package eps_pkg;

  localparam int OP_BITS        = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int TIMER_REG_BITS = 16;
  localparam int ATTEMPT_BITS   = 8;
  localparam int STATUS_BITS    = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK      = 3'd0,
    OP_SET_ADDR  = 3'd1,
    OP_READ      = 3'd2,
    OP_PROGRAM   = 3'd3,
    OP_BLANK     = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RSET    = 4'd1,
    PH_BSET    = 4'd2,
    PH_PSET    = 4'd3,
    PH_SETUP   = 4'd4,
    PH_PULSE   = 4'd5,
    PH_HOLD    = 4'd6,
    PH_FLOAT   = 4'd7,
    PH_VERIFY  = 4'd8,
    PH_RECOVER = 4'd9
  } phase_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_PROG_FAIL = 2'd1,
    ST_NOT_BLANK = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ADDR_SETTLE  = 3'd0,
    CFG_DATA_SETUP   = 3'd1,
    CFG_PULSE        = 3'd2,
    CFG_DATA_HOLD    = 3'd3,
    CFG_FLOAT        = 3'd4,
    CFG_VERIFY_OE    = 3'd5,
    CFG_RECOVERY     = 3'd6,
    CFG_MAX_ATTEMPTS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [TIMER_REG_BITS-1:0] addr_settle_ticks;
    logic [TIMER_REG_BITS-1:0] data_setup_ticks;
    logic [TIMER_REG_BITS-1:0] pulse_ticks;
    logic [TIMER_REG_BITS-1:0] data_hold_ticks;
    logic [TIMER_REG_BITS-1:0] float_ticks;
    logic [TIMER_REG_BITS-1:0] verify_oe_ticks;
    logic [TIMER_REG_BITS-1:0] recovery_ticks;
    logic [ATTEMPT_BITS-1:0]   max_attempts;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    addr_settle_ticks: 16'd1,
    data_setup_ticks:  16'd15,
    pulse_ticks:       16'd50,
    data_hold_ticks:   16'd15,
    float_ticks:       16'd50,
    verify_oe_ticks:   16'd5,
    recovery_ticks:    16'd1,
    max_attempts:      8'd25
  };

  localparam logic [ATTEMPT_BITS-1:0] FAIL_COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic data_drive;
    logic chip_enable_n;
    logic output_enable_n;
  } pins_t;

endpackage

@@ rtl/eps_if.sv @@
interface eps_in_if #(
  parameter int ADDR_BITS = 20,
  parameter int DATA_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [eps_pkg::OP_BITS-1:0]  operation;
  logic [ADDR_BITS-1:0]         address;
  logic [DATA_BITS-1:0]         write_data;
  logic [DATA_BITS-1:0]         bus_in;

  modport source (output valid, operation, address, write_data, bus_in, input ready);
  modport sink   (input valid, operation, address, write_data, bus_in, output ready);
endinterface

interface eps_out_if #(
  parameter int ADDR_BITS = 20,
  parameter int DATA_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic [ADDR_BITS-1:0]             address_pins;
  logic [DATA_BITS-1:0]             data_pins_out;
  logic                             data_drive;
  logic                             chip_enable_n;
  logic                             output_enable_n;
  logic                             busy_res;
  logic                             done_res;
  logic [eps_pkg::STATUS_BITS-1:0]  status;
  logic [DATA_BITS-1:0]             read_data;
  logic [eps_pkg::ATTEMPT_BITS-1:0] attempts_used;

  modport source (output valid, address_pins, data_pins_out, data_drive, chip_enable_n,
                  output_enable_n, busy_res, done_res, status, read_data, attempts_used,
                  input ready);
  modport sink   (input valid, address_pins, data_pins_out, data_drive, chip_enable_n,
                  output_enable_n, busy_res, done_res, status, read_data, attempts_used,
                  output ready);
endinterface

interface eps_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [eps_pkg::CFG_IDX_BITS-1:0]   index;
  logic [eps_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/eprom_program_verify_sequencer.sv @@
// EPROM program/verify sequencer. Each transfer on in_i is one timer tick and may carry a
// command (set address, read, program, blank check); commands arriving while busy are
// ignored. Every tick yields exactly one transfer on out_o with the pin levels for that
// tick and the sequencer status. A tick is registered at the input, evaluated in one pass
// against the phase state and counters, and registered at the output. One tick is taken per
// cycle while out_o keeps up. Phase durations and the retry limit come from the cfg_i
// register port and may only change while the block is idle.
module eprom_program_verify_sequencer #(
  parameter int ADDR_BITS  = 20,
  parameter int DATA_BITS  = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  eps_in_if.sink    in_i,
  eps_out_if.source out_o,
  eps_cfg_if.sink   cfg_i
);
  import eps_pkg::*;

  cfg_t cfg;

  logic                    in_vld_q, in_vld_d;
  logic [OP_BITS-1:0]      op_q;
  logic [ADDR_BITS-1:0]    addr_q;
  logic [DATA_BITS-1:0]    wdata_q;
  logic [DATA_BITS-1:0]    bus_q;
  logic                    step;
  logic                    in_take;

  logic                    out_vld_q, out_vld_d;

  logic [ADDR_BITS-1:0]    res_addr, res_addr_q;
  logic [DATA_BITS-1:0]    res_dout, res_dout_q;
  pins_t                   res_pins, res_pins_q;
  logic                    res_busy, res_busy_q;
  logic                    res_done, res_done_q;
  logic [STATUS_BITS-1:0]  res_status, res_status_q;
  logic [DATA_BITS-1:0]    res_rdata, res_rdata_q;
  logic [ATTEMPT_BITS-1:0] res_att, res_att_q;

  eps_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign step       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  eps_seq #(
    .ADDR_BITS  (ADDR_BITS),
    .DATA_BITS  (DATA_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .cfg_i      (cfg),
    .op_i       (op_q),
    .addr_i     (addr_q),
    .wdata_i    (wdata_q),
    .bus_i      (bus_q),
    .addr_o     (res_addr),
    .dout_o     (res_dout),
    .pins_o     (res_pins),
    .busy_o     (res_busy),
    .done_o     (res_done),
    .status_o   (res_status),
    .rdata_o    (res_rdata),
    .attempts_o (res_att)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= in_i.operation;
      addr_q  <= in_i.address;
      wdata_q <= in_i.write_data;
      bus_q   <= in_i.bus_in;
    end
    if (step) begin
      res_addr_q   <= res_addr;
      res_dout_q   <= res_dout;
      res_pins_q   <= res_pins;
      res_busy_q   <= res_busy;
      res_done_q   <= res_done;
      res_status_q <= res_status;
      res_rdata_q  <= res_rdata;
      res_att_q    <= res_att;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.address_pins    = res_addr_q;
  assign out_o.data_pins_out   = res_dout_q;
  assign out_o.data_drive      = res_pins_q.data_drive;
  assign out_o.chip_enable_n   = res_pins_q.chip_enable_n;
  assign out_o.output_enable_n = res_pins_q.output_enable_n;
  assign out_o.busy_res        = res_busy_q;
  assign out_o.done_res        = res_done_q;
  assign out_o.status          = res_status_q;
  assign out_o.read_data       = res_rdata_q;
  assign out_o.attempts_used   = res_att_q;

endmodule

@@ rtl/eps_cfg_regs.sv @@
module eps_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  eps_cfg_if.sink       cfg_i,
  output eps_pkg::cfg_t cfg_o
);
  import eps_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ADDR_SETTLE:  cfg_d.addr_settle_ticks = cfg_i.data;
        CFG_DATA_SETUP:   cfg_d.data_setup_ticks  = cfg_i.data;
        CFG_PULSE:        cfg_d.pulse_ticks       = cfg_i.data;
        CFG_DATA_HOLD:    cfg_d.data_hold_ticks   = cfg_i.data;
        CFG_FLOAT:        cfg_d.float_ticks       = cfg_i.data;
        CFG_VERIFY_OE:    cfg_d.verify_oe_ticks   = cfg_i.data;
        CFG_RECOVERY:     cfg_d.recovery_ticks    = cfg_i.data;
        CFG_MAX_ATTEMPTS: cfg_d.max_attempts      = cfg_i.data[ATTEMPT_BITS-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/eps_seq.sv @@
module eps_seq #(
  parameter int ADDR_BITS  = 20,
  parameter int DATA_BITS  = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  eps_pkg::cfg_t                    cfg_i,
  input  logic [eps_pkg::OP_BITS-1:0]      op_i,
  input  logic [ADDR_BITS-1:0]             addr_i,
  input  logic [DATA_BITS-1:0]             wdata_i,
  input  logic [DATA_BITS-1:0]             bus_i,
  output logic [ADDR_BITS-1:0]             addr_o,
  output logic [DATA_BITS-1:0]             dout_o,
  output eps_pkg::pins_t                   pins_o,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [eps_pkg::STATUS_BITS-1:0]  status_o,
  output logic [DATA_BITS-1:0]             rdata_o,
  output logic [eps_pkg::ATTEMPT_BITS-1:0] attempts_o
);
  import eps_pkg::*;

  localparam int LW = ((TIMER_BITS > TIMER_REG_BITS) ? TIMER_BITS : TIMER_REG_BITS) + 1;
  localparam logic [DATA_BITS-1:0] BLANK_WORD = '1;

  phase_e                  phase_q, phase_d, phase_s;
  logic [ADDR_BITS-1:0]    addr_q, addr_d, addr_s;
  logic [TIMER_BITS-1:0]   tick_q, tick_d, tick_s;
  logic [ATTEMPT_BITS-1:0] fail_q, fail_d, fail_s;
  logic [DATA_BITS-1:0]    held_q, held_d;
  logic [DATA_BITS-1:0]    rd_q, rd_d;
  status_e                 status_q, status_d, status_s;
  logic                    vok_q, vok_d, vok_s;
  logic                    done_s, done_d;

  logic [TIMER_REG_BITS-1:0] len_sel;
  logic [LW-1:0]             len;
  logic                      phase_end;
  logic [ATTEMPT_BITS-1:0]   limit;

  // command decode while idle
  always_comb begin
    phase_s  = phase_q;
    addr_s   = addr_q;
    tick_s   = tick_q;
    fail_s   = fail_q;
    held_d   = held_q;
    status_s = status_q;
    vok_s    = vok_q;
    done_s   = 1'b0;
    if (phase_q == PH_IDLE) begin
      case (op_i)
        OP_SET_ADDR: begin
          addr_s   = addr_i;
          status_s = ST_OK;
          done_s   = 1'b1;
        end
        OP_READ: begin
          phase_s = PH_RSET;
          tick_s  = '0;
        end
        OP_PROGRAM: begin
          held_d  = wdata_i;
          fail_s  = '0;
          vok_s   = 1'b0;
          phase_s = PH_PSET;
          tick_s  = '0;
        end
        OP_BLANK: begin
          phase_s = PH_BSET;
          tick_s  = '0;
        end
        default: phase_s = phase_q;
      endcase
    end
  end

  // pin levels for the current tick
  always_comb begin
    pins_o = '{data_drive: 1'b0, chip_enable_n: 1'b1, output_enable_n: 1'b1};
    dout_o = '0;
    case (phase_s)
      PH_RSET, PH_BSET: begin
        pins_o.chip_enable_n   = 1'b0;
        pins_o.output_enable_n = 1'b0;
      end
      PH_SETUP, PH_HOLD: begin
        pins_o.data_drive = 1'b1;
        dout_o            = held_d;
      end
      PH_PULSE: begin
        pins_o.data_drive    = 1'b1;
        pins_o.chip_enable_n = 1'b0;
        dout_o               = held_d;
      end
      PH_VERIFY: pins_o.output_enable_n = 1'b0;
      default:   dout_o = '0;
    endcase
  end

  always_comb begin
    case (phase_s)
      PH_RSET, PH_BSET, PH_PSET: len_sel = cfg_i.addr_settle_ticks;
      PH_SETUP:                  len_sel = cfg_i.data_setup_ticks;
      PH_PULSE:                  len_sel = cfg_i.pulse_ticks;
      PH_HOLD:                   len_sel = cfg_i.data_hold_ticks;
      PH_FLOAT:                  len_sel = cfg_i.float_ticks;
      PH_VERIFY:                 len_sel = cfg_i.verify_oe_ticks;
      default:                   len_sel = cfg_i.recovery_ticks;
    endcase
    len = LW'(len_sel);
    if (len > (LW'(1) << TIMER_BITS)) begin
      len = LW'(1) << TIMER_BITS;
    end
    if (len == '0) begin
      len = LW'(1);
    end
    phase_end = (LW'(tick_s) + LW'(1)) >= len;
    limit     = (cfg_i.max_attempts == '0) ? ATTEMPT_BITS'(1) : cfg_i.max_attempts;
  end

  // phase advance
  always_comb begin
    phase_d  = phase_s;
    addr_d   = addr_s;
    tick_d   = tick_s;
    fail_d   = fail_s;
    rd_d     = rd_q;
    status_d = status_s;
    vok_d    = vok_s;
    done_d   = done_s;
    if (phase_s != PH_IDLE) begin
      if (phase_end) begin
        tick_d = '0;
        case (phase_s)
          PH_RSET: begin
            rd_d     = bus_i;
            status_d = ST_OK;
            addr_d   = addr_s + ADDR_BITS'(1);
            phase_d  = PH_IDLE;
            done_d   = 1'b1;
          end
          PH_BSET: begin
            rd_d = bus_i;
            if (bus_i != BLANK_WORD) begin
              status_d = ST_NOT_BLANK;
            end else begin
              status_d = ST_OK;
              addr_d   = addr_s + ADDR_BITS'(1);
            end
            phase_d = PH_IDLE;
            done_d  = 1'b1;
          end
          PH_VERIFY: begin
            vok_d = (bus_i == held_d);
            if (bus_i != held_d && fail_s < FAIL_COUNT_MAX) begin
              fail_d = fail_s + ATTEMPT_BITS'(1);
            end
            phase_d = PH_RECOVER;
          end
          PH_RECOVER: begin
            if (vok_s) begin
              status_d = ST_OK;
              addr_d   = addr_s + ADDR_BITS'(1);
              phase_d  = PH_IDLE;
              done_d   = 1'b1;
            end else if (fail_s >= limit) begin
              status_d = ST_PROG_FAIL;
              phase_d  = PH_IDLE;
              done_d   = 1'b1;
            end else begin
              phase_d = PH_SETUP;
            end
          end
          PH_PSET:  phase_d = PH_SETUP;
          PH_SETUP: phase_d = PH_PULSE;
          PH_PULSE: phase_d = PH_HOLD;
          PH_HOLD:  phase_d = PH_FLOAT;
          PH_FLOAT: phase_d = PH_VERIFY;
          default:  phase_d = PH_IDLE;
        endcase
      end else begin
        tick_d = tick_s + TIMER_BITS'(1);
      end
    end
  end

  assign addr_o     = addr_d;
  assign busy_o     = (phase_d != PH_IDLE);
  assign done_o     = done_d;
  assign status_o   = status_d;
  assign rdata_o    = rd_d;
  assign attempts_o = fail_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      addr_q   <= '0;
      tick_q   <= '0;
      fail_q   <= '0;
      held_q   <= '0;
      rd_q     <= '0;
      status_q <= ST_OK;
      vok_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      tick_q   <= tick_d;
      fail_q   <= fail_d;
      held_q   <= held_d;
      rd_q     <= rd_d;
      status_q <= status_d;
      vok_q    <= vok_d;
    end
  end

endmodule

@@ test/eprom_pin_checker.sv @@
`timescale 1ns / 100ps

module eprom_pin_checker
  import eps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  eps_in_if           in_i,
  eps_out_if          out_i,
  eps_cfg_if          cfg_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output logic        busy_o
);

  typedef struct packed {
    logic [19:0] address_pins;
    logic [15:0] data_pins_out;
    logic        data_drive;
    logic        chip_enable_n;
    logic        output_enable_n;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] read_data;
    logic [7:0]  attempts_used;
  } pin_frame_t;

  pin_frame_t  pin_frames_q[$];
  cfg_t        timing_q;
  phase_e      phase_q;
  logic [19:0] addr_q;
  logic [15:0] tick_q;
  logic [7:0]  fails_q;
  logic [15:0] word_q;
  logic [15:0] sampled_q;
  status_e     status_q;
  logic        verified_q;

  function automatic logic [16:0] span_of(phase_e ph);
    logic [15:0] d;
    case (ph)
      PH_RSET, PH_BSET, PH_PSET: d = timing_q.addr_settle_ticks;
      PH_SETUP:                  d = timing_q.data_setup_ticks;
      PH_PULSE:                  d = timing_q.pulse_ticks;
      PH_HOLD:                   d = timing_q.data_hold_ticks;
      PH_FLOAT:                  d = timing_q.float_ticks;
      PH_VERIFY:                 d = timing_q.verify_oe_ticks;
      default:                   d = timing_q.recovery_ticks;
    endcase
    return (d == '0) ? 17'd1 : {1'b0, d};
  endfunction

  task automatic predict_tick(input logic [2:0] op, input logic [19:0] addr,
                              input logic [15:0] wdata, input logic [15:0] bus);
    pin_frame_t f;
    logic [7:0] limit;
    f = '0;
    f.chip_enable_n = 1'b1;
    f.output_enable_n = 1'b1;
    if (phase_q == PH_IDLE) begin
      case (op)
        OP_SET_ADDR: begin
          addr_q = addr;
          status_q = ST_OK;
          f.done_res = 1'b1;
        end
        OP_READ: begin
          phase_q = PH_RSET;
          tick_q = '0;
        end
        OP_PROGRAM: begin
          word_q = wdata;
          fails_q = '0;
          verified_q = 1'b0;
          phase_q = PH_PSET;
          tick_q = '0;
        end
        OP_BLANK: begin
          phase_q = PH_BSET;
          tick_q = '0;
        end
        default: ;
      endcase
    end

    case (phase_q)
      PH_RSET, PH_BSET: begin
        f.chip_enable_n = 1'b0;
        f.output_enable_n = 1'b0;
      end
      PH_SETUP, PH_HOLD: begin
        f.data_drive = 1'b1;
        f.data_pins_out = word_q;
      end
      PH_PULSE: begin
        f.data_drive = 1'b1;
        f.data_pins_out = word_q;
        f.chip_enable_n = 1'b0;
      end
      PH_VERIFY: f.output_enable_n = 1'b0;
      default: ;
    endcase

    if (phase_q != PH_IDLE) begin
      if ({1'b0, tick_q} + 17'd1 >= span_of(phase_q)) begin
        tick_q = '0;
        case (phase_q)
          PH_RSET: begin
            sampled_q = bus;
            status_q = ST_OK;
            addr_q = addr_q + 20'd1;
            phase_q = PH_IDLE;
            f.done_res = 1'b1;
          end
          PH_BSET: begin
            sampled_q = bus;
            if (bus != 16'hFFFF) begin
              status_q = ST_NOT_BLANK;
            end else begin
              status_q = ST_OK;
              addr_q = addr_q + 20'd1;
            end
            phase_q = PH_IDLE;
            f.done_res = 1'b1;
          end
          PH_VERIFY: begin
            verified_q = (bus == word_q);
            if (!verified_q && fails_q != FAIL_COUNT_MAX) fails_q = fails_q + 8'd1;
            phase_q = PH_RECOVER;
          end
          PH_RECOVER: begin
            limit = (timing_q.max_attempts == '0) ? 8'd1 : timing_q.max_attempts;
            if (verified_q) begin
              status_q = ST_OK;
              addr_q = addr_q + 20'd1;
              phase_q = PH_IDLE;
              f.done_res = 1'b1;
            end else if (fails_q >= limit) begin
              status_q = ST_PROG_FAIL;
              phase_q = PH_IDLE;
              f.done_res = 1'b1;
            end else begin
              phase_q = PH_SETUP;
            end
          end
          default: phase_q = phase_e'(phase_q + 4'd1);
        endcase
      end else begin
        tick_q = tick_q + 16'd1;
      end
    end

    f.address_pins = addr_q;
    f.busy_res = (phase_q != PH_IDLE);
    f.status = status_q;
    f.read_data = sampled_q;
    f.attempts_used = fails_q;
    pin_frames_q.push_back(f);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches_o++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_frame();
    pin_frame_t f;
    if (pin_frames_q.size() == 0) begin
      mismatches_o++;
      $display("%0t: result transfer with nothing expected", $time);
    end else begin
      f = pin_frames_q.pop_front();
      check_field("address_pins", 32'(f.address_pins), 32'(out_i.address_pins));
      check_field("data_pins_out", 32'(f.data_pins_out), 32'(out_i.data_pins_out));
      check_field("data_drive", 32'(f.data_drive), 32'(out_i.data_drive));
      check_field("chip_enable_n", 32'(f.chip_enable_n), 32'(out_i.chip_enable_n));
      check_field("output_enable_n", 32'(f.output_enable_n),
                  32'(out_i.output_enable_n));
      check_field("busy_res", 32'(f.busy_res), 32'(out_i.busy_res));
      check_field("done_res", 32'(f.done_res), 32'(out_i.done_res));
      check_field("status", 32'(f.status), 32'(out_i.status));
      check_field("read_data", 32'(f.read_data), 32'(out_i.read_data));
      check_field("attempts_used", 32'(f.attempts_used), 32'(out_i.attempts_used));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_frames_q.delete();
      timing_q = CFG_RESET;
      phase_q = PH_IDLE;
      addr_q = '0;
      tick_q = '0;
      fails_q = '0;
      word_q = '0;
      sampled_q = '0;
      status_q = ST_OK;
      verified_q = 1'b0;
      mismatches_o = 0;
      pending_o = 0;
      busy_o = 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_ADDR_SETTLE:  timing_q.addr_settle_ticks = cfg_i.data;
          CFG_DATA_SETUP:   timing_q.data_setup_ticks = cfg_i.data;
          CFG_PULSE:        timing_q.pulse_ticks = cfg_i.data;
          CFG_DATA_HOLD:    timing_q.data_hold_ticks = cfg_i.data;
          CFG_FLOAT:        timing_q.float_ticks = cfg_i.data;
          CFG_VERIFY_OE:    timing_q.verify_oe_ticks = cfg_i.data;
          CFG_RECOVERY:     timing_q.recovery_ticks = cfg_i.data;
          CFG_MAX_ATTEMPTS: timing_q.max_attempts = cfg_i.data[7:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        predict_tick(in_i.operation, in_i.address, in_i.write_data, in_i.bus_in);
      end
      if (out_i.valid && out_i.ready) begin
        check_frame();
      end
      pending_o = pin_frames_q.size();
      busy_o = (phase_q != PH_IDLE);
    end
  end

endmodule

@@ test/eprom_program_verify_sequencer_tb.sv @@
`timescale 1ns / 100ps

module eprom_program_verify_sequencer_tb;
  import eps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  logic        model_busy;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt = 0;
  logic [15:0] prog_word;
  logic [2:0]  running_op;

  eps_in_if  in_ch ();
  eps_out_if out_ch ();
  eps_cfg_if cfg_ch ();

  eprom_program_verify_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  eprom_pin_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_i        (cfg_ch),
    .mismatches_o (mismatch_cnt),
    .pending_o    (pending_cnt),
    .busy_o       (model_busy)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  task automatic send_tick(input logic [2:0] op, input logic [19:0] addr,
                           input logic [15:0] wdata, input logic [15:0] bus);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.address <= addr;
    in_ch.write_data <= wdata;
    in_ch.bus_in <= bus;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // issue one command and tick until the sequencer is idle again
  task automatic do_command(input logic [2:0] op, input logic [19:0] addr,
                            input logic [15:0] wdata, input logic [15:0] bus,
                            input logic [2:0] busy_op);
    send_tick(op, addr, wdata, bus);
    while (model_busy) send_tick(busy_op, 20'($urandom), 16'($urandom), bus);
  endtask

  task automatic drain();
    while (model_busy) send_tick(OP_TICK, 20'($urandom), 16'($urandom), 16'($urandom));
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic apply_timing(input cfg_t t);
    drain();
    write_reg(CFG_ADDR_SETTLE, t.addr_settle_ticks);
    write_reg(CFG_DATA_SETUP, t.data_setup_ticks);
    write_reg(CFG_PULSE, t.pulse_ticks);
    write_reg(CFG_DATA_HOLD, t.data_hold_ticks);
    write_reg(CFG_FLOAT, t.float_ticks);
    write_reg(CFG_VERIFY_OE, t.verify_oe_ticks);
    write_reg(CFG_RECOVERY, t.recovery_ticks);
    write_reg(CFG_MAX_ATTEMPTS, {8'd0, t.max_attempts});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_ticks();
    return ($urandom_range(9) == 0) ? 16'($urandom_range(30)) : 16'($urandom_range(3));
  endfunction

  function automatic cfg_t random_timing();
    cfg_t t;
    t.addr_settle_ticks = pick_ticks();
    t.data_setup_ticks = pick_ticks();
    t.pulse_ticks = pick_ticks();
    t.data_hold_ticks = pick_ticks();
    t.float_ticks = pick_ticks();
    t.verify_oe_ticks = pick_ticks();
    t.recovery_ticks = pick_ticks();
    t.max_attempts = 8'($urandom_range(6));
    return t;
  endfunction

  task automatic random_tick();
    logic [2:0]  op;
    logic [19:0] addr;
    logic [15:0] wdata;
    logic [15:0] bus;
    addr = ($urandom_range(7) == 0) ? 20'hFFFFF : 20'($urandom);
    wdata = 16'($urandom);
    if (!model_busy) begin
      case ($urandom_range(11))
        0:       op = OP_TICK;
        1, 2:    op = OP_SET_ADDR;
        3, 4, 5: op = OP_READ;
        6, 7, 8: op = OP_PROGRAM;
        9, 10:   op = OP_BLANK;
        default: op = 3'($urandom);
      endcase
      running_op = op;
      if (op == OP_PROGRAM) prog_word = wdata;
    end else begin
      op = ($urandom_range(3) == 0) ? 3'($urandom) : OP_TICK;
    end
    case (running_op)
      OP_PROGRAM: bus = ($urandom_range(9) < 7) ? prog_word : 16'($urandom);
      OP_BLANK:   bus = ($urandom_range(1) == 0) ? 16'hFFFF : 16'($urandom);
      default:    bus = 16'($urandom);
    endcase
    send_tick(op, addr, wdata, bus);
  endtask

  initial begin
    cfg_t        t;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.address = '0;
    in_ch.write_data = '0;
    in_ch.bus_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ADDR_SETTLE;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    prog_word = '0;
    running_op = OP_TICK;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset timing: plain ticks, unknown codes, wrap, read, blank and program cases
    do_command(OP_TICK, 20'h00000, 16'h0000, 16'h0000, OP_TICK);
    do_command(3'd5, 20'hFFFFF, 16'hFFFF, 16'hFFFF, OP_TICK);
    do_command(3'd6, 20'h55555, 16'hAAAA, 16'h5555, OP_TICK);
    do_command(3'd7, 20'hAAAAA, 16'h5555, 16'hAAAA, OP_TICK);
    do_command(OP_SET_ADDR, 20'hFFFFF, 16'h0000, 16'h0000, OP_TICK);
    do_command(OP_READ, 20'h12345, 16'h0000, 16'h0000, OP_PROGRAM);
    do_command(OP_SET_ADDR, 20'hFFFFE, 16'h0000, 16'h0000, OP_TICK);
    do_command(OP_BLANK, 20'h00000, 16'h0000, 16'hFFFF, OP_READ);
    do_command(OP_BLANK, 20'h00000, 16'h0000, 16'h7FFF, OP_TICK);
    do_command(OP_READ, 20'h00000, 16'h0000, 16'hA5A5, OP_SET_ADDR);
    do_command(OP_PROGRAM, 20'h00000, 16'h0000, 16'h0000, OP_SET_ADDR);
    do_command(OP_PROGRAM, 20'h00000, 16'hFFFF, 16'hFFFF, OP_BLANK);
    do_command(OP_PROGRAM, 20'h00000, 16'h4321, 16'h4321, OP_TICK);
    do_command(OP_SET_ADDR, 20'h00000, 16'h0000, 16'h0000, OP_TICK);

    // all durations zero, zero attempt limit
    t = '0;
    apply_timing(t);
    do_command(OP_PROGRAM, 20'h00000, 16'h5A5A, 16'hA5A5, OP_TICK);
    do_command(OP_PROGRAM, 20'h00000, 16'h5A5A, 16'h5A5A, OP_TICK);
    do_command(OP_READ, 20'h00000, 16'h0000, 16'hC3C3, OP_TICK);
    do_command(OP_BLANK, 20'h00000, 16'h0000, 16'hFFFF, OP_TICK);

    // high attempt limit, never verifies
    t.max_attempts = 8'd30;
    apply_timing(t);
    do_command(OP_PROGRAM, 20'h00000, 16'h00FF, 16'hFF00, OP_TICK);

    // long address settle
    t = '0;
    t.addr_settle_ticks = 16'd120;
    apply_timing(t);
    do_command(OP_READ, 20'h00000, 16'h0000, 16'hBEEF, OP_TICK);

    for (int p = 0; p < 8; p++) begin
      apply_timing(random_timing());
      set_idling(p);
      repeat (130) random_tick();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
